@@ rtl/core/nnps_pkg.sv @@
// Shared types and constants of the nearest-neighbor preview scaler.
package nnps_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_SRC_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_SRC_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_OUT_WIDTH    = 3'd2;
  localparam logic [2:0] CFG_OUT_HEIGHT   = 3'd3;
  localparam logic [2:0] CFG_CHANNEL_MODE = 3'd4;
  localparam logic [2:0] CFG_MIRROR_ROWS  = 3'd5;

  // Channel mode codes; any other code means four channels.
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;

  localparam logic [7:0] OPAQUE_ALPHA = 8'd255;

  localparam int unsigned DIM_W = 13;
  localparam int unsigned POS_W = 12;
  localparam int unsigned IDX_W = 26;

  // Effective image dimensions after zero and range clamping.
  typedef struct packed {
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [DIM_W-1:0] out_w;
    logic [DIM_W-1:0] out_h;
  } nnps_geom_t;

  // DDA step values derived from the geometry.
  typedef struct packed {
    logic [DIM_W-1:0] col_quo;
    logic [DIM_W-1:0] col_rem;
    logic [DIM_W-1:0] row_rem;
    logic [IDX_W-1:0] row_step;
  } nnps_step_t;

  // Payload passed from the walk stage to the output stage.
  typedef struct packed {
    logic [3:0][7:0]  samples;
    logic [POS_W-1:0] dest_row;
    logic [POS_W-1:0] dest_col;
    logic [IDX_W-1:0] next_pix;
    logic             last;
  } nnps_stage_t;

endpackage

@@ rtl/core/nnps_step_div.sv @@
// Iterative divider that derives the DDA step values from the geometry.
module nnps_step_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  nnps_pkg::nnps_geom_t geom_i,
  output nnps_pkg::nnps_step_t step_o,
  output logic                busy_o
);
  import nnps_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_RUN  = 2'd2;
  localparam logic [1:0] ST_MUL  = 2'd3;
  localparam logic [3:0] LastStep = 4'(DIM_W - 1);

  logic [1:0]       state_q, state_d;
  logic [3:0]       cnt_q, cnt_d;
  logic [DIM_W:0]   col_r_q, col_r_d, row_r_q, row_r_d;
  logic [DIM_W-1:0] col_n_q, col_n_d, row_n_q, row_n_d;
  logic [DIM_W:0]   col_trial, row_trial;
  logic             col_ge, row_ge;
  nnps_step_t       step_q, step_d;

  // One restoring division step for each of the two quotients.
  always_comb begin
    col_trial = {col_r_q[DIM_W-1:0], col_n_q[DIM_W-1]};
    row_trial = {row_r_q[DIM_W-1:0], row_n_q[DIM_W-1]};
    col_ge    = col_trial >= {1'b0, geom_i.out_w};
    row_ge    = row_trial >= {1'b0, geom_i.out_h};
  end

  // Sequencer: load operands, run one bit per cycle, then scale the row step.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    col_r_d = col_r_q;
    row_r_d = row_r_q;
    col_n_d = col_n_q;
    row_n_d = row_n_q;
    step_d  = step_q;
    case (state_q)
      ST_LOAD: begin
        col_r_d = '0;
        row_r_d = '0;
        col_n_d = geom_i.src_w;
        row_n_d = geom_i.src_h;
        cnt_d   = '0;
        state_d = ST_RUN;
      end
      ST_RUN: begin
        col_r_d = col_ge ? col_trial - {1'b0, geom_i.out_w} : col_trial;
        row_r_d = row_ge ? row_trial - {1'b0, geom_i.out_h} : row_trial;
        col_n_d = {col_n_q[DIM_W-2:0], col_ge};
        row_n_d = {row_n_q[DIM_W-2:0], row_ge};
        cnt_d   = cnt_q + 4'd1;
        if (cnt_q == LastStep) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        step_d.col_quo  = col_n_q;
        step_d.col_rem  = col_r_q[DIM_W-1:0];
        step_d.row_rem  = row_r_q[DIM_W-1:0];
        step_d.row_step = IDX_W'(geom_i.src_w) * IDX_W'(row_n_q);
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (start_i) begin
      state_d = ST_LOAD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      step_q.col_quo  <= DIM_W'(1);
      step_q.col_rem  <= '0;
      step_q.row_rem  <= '0;
      step_q.row_step <= IDX_W'(1);
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Datapath registers of the divider.
  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    col_r_q <= col_r_d;
    row_r_q <= row_r_d;
    col_n_q <= col_n_d;
    row_n_q <= row_n_d;
  end

  assign step_o = step_q;
  assign busy_o = state_q != ST_IDLE;

endmodule

@@ rtl/core/nnps_walk.sv @@
// Raster walk with DDA accumulators and the input-side pipeline register.
module nnps_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 restart_i,
  input  logic                 accept_i,
  input  logic [3:0][7:0]      samples_i,
  input  nnps_pkg::nnps_geom_t geom_i,
  input  nnps_pkg::nnps_step_t step_i,
  input  logic                 mirror_i,
  input  logic                 down_ready_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output nnps_pkg::nnps_stage_t stage_o
);
  import nnps_pkg::*;

  logic [DIM_W-1:0] out_col_q, out_col_d, out_row_q, out_row_d;
  logic [DIM_W-1:0] col_acc_q, col_acc_d, row_acc_q, row_acc_d;
  logic [IDX_W-1:0] lin_q, lin_d, row_base_q, row_base_d;
  logic [DIM_W:0]   col_sum, row_sum;
  logic             col_carry, row_carry, end_col, end_row;
  logic [DIM_W-1:0] drow;
  logic             valid_q;
  nnps_stage_t      stage_q;

  // Next walk position and source element offset for one accepted beat.
  always_comb begin
    end_col    = ({1'b0, out_col_q} + (DIM_W+1)'(1)) >= {1'b0, geom_i.out_w};
    end_row    = ({1'b0, out_row_q} + (DIM_W+1)'(1)) >= {1'b0, geom_i.out_h};
    col_sum    = {1'b0, col_acc_q} + {1'b0, step_i.col_rem};
    row_sum    = {1'b0, row_acc_q} + {1'b0, step_i.row_rem};
    col_carry  = col_sum >= {1'b0, geom_i.out_w};
    row_carry  = row_sum >= {1'b0, geom_i.out_h};
    drow       = mirror_i ? geom_i.out_h - DIM_W'(1) - out_row_q : out_row_q;
    out_col_d  = out_col_q;
    out_row_d  = out_row_q;
    col_acc_d  = col_acc_q;
    row_acc_d  = row_acc_q;
    lin_d      = lin_q;
    row_base_d = row_base_q;
    if (end_col) begin
      out_col_d = '0;
      col_acc_d = '0;
      if (end_row) begin
        // End of frame: wrap back to the first pixel.
        out_row_d  = '0;
        row_acc_d  = '0;
        row_base_d = '0;
        lin_d      = '0;
      end else begin
        out_row_d  = out_row_q + DIM_W'(1);
        row_acc_d  = row_carry ? DIM_W'(row_sum - {1'b0, geom_i.out_h})
                               : row_sum[DIM_W-1:0];
        row_base_d = row_base_q + step_i.row_step
                   + (row_carry ? IDX_W'(geom_i.src_w) : '0);
        lin_d      = row_base_d;
      end
    end else begin
      out_col_d = out_col_q + DIM_W'(1);
      col_acc_d = col_carry ? DIM_W'(col_sum - {1'b0, geom_i.out_w})
                            : col_sum[DIM_W-1:0];
      lin_d     = lin_q + IDX_W'(step_i.col_quo) + IDX_W'(col_carry);
    end
  end

  // Walk state advances on every accepted beat; a register write restarts it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q  <= '0;
      out_row_q  <= '0;
      col_acc_q  <= '0;
      row_acc_q  <= '0;
      lin_q      <= '0;
      row_base_q <= '0;
    end else if (restart_i) begin
      out_col_q  <= '0;
      out_row_q  <= '0;
      col_acc_q  <= '0;
      row_acc_q  <= '0;
      lin_q      <= '0;
      row_base_q <= '0;
    end else if (accept_i) begin
      out_col_q  <= out_col_d;
      out_row_q  <= out_row_d;
      col_acc_q  <= col_acc_d;
      row_acc_q  <= row_acc_d;
      lin_q      <= lin_d;
      row_base_q <= row_base_d;
    end
  end

  assign ready_o = !valid_q || down_ready_i;

  // Pipeline register toward the output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= accept_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && accept_i) begin
      stage_q.samples  <= samples_i;
      stage_q.dest_row <= drow[POS_W-1:0];
      stage_q.dest_col <= out_col_q[POS_W-1:0];
      stage_q.next_pix <= lin_d;
      stage_q.last     <= end_col && end_row;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

@@ rtl/core/nnps_pack.sv @@
// Pixel packing, channel scaling of the source index and the output register.
module nnps_pack (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  nnps_pkg::nnps_stage_t stage_i,
  input  logic [1:0]            mode_i,
  output logic                  ready_o,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic [31:0]           pixel_word_o,
  output logic [11:0]           dest_row_o,
  output logic [11:0]           dest_col_o,
  output logic [25:0]           next_index_o,
  output logic                  last_o
);
  import nnps_pkg::*;

  logic [31:0]      word;
  logic [IDX_W-1:0] index;
  logic [IDX_W-1:0] pix;
  logic             valid_q;
  logic [31:0]      word_q;
  logic [POS_W-1:0] row_q, col_q;
  logic [IDX_W-1:0] index_q;
  logic             last_q;

  // ARGB packing and pixel-to-element index scaling by the channel count.
  always_comb begin
    pix = stage_i.next_pix;
    case (mode_i)
      MODE_GRAY: begin
        word  = {OPAQUE_ALPHA, stage_i.samples[0], stage_i.samples[0],
                 stage_i.samples[0]};
        index = pix;
      end
      MODE_RGB: begin
        word  = {OPAQUE_ALPHA, stage_i.samples[0], stage_i.samples[1],
                 stage_i.samples[2]};
        index = pix + {pix[IDX_W-2:0], 1'b0};
      end
      default: begin
        word  = {stage_i.samples[3], stage_i.samples[0], stage_i.samples[1],
                 stage_i.samples[2]};
        index = {pix[IDX_W-3:0], 2'b00};
      end
    endcase
  end

  assign ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Result register; holds while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      word_q  <= word;
      row_q   <= stage_i.dest_row;
      col_q   <= stage_i.dest_col;
      index_q <= index;
      last_q  <= stage_i.last;
    end
  end

  assign out_valid_o  = valid_q;
  assign pixel_word_o = word_q;
  assign dest_row_o   = row_q;
  assign dest_col_o   = col_q;
  assign next_index_o = index_q;
  assign last_o       = last_q;

endmodule

@@ rtl/core/nearest_neighbor_preview_scaler.sv @@
// Top level of the nearest-neighbor preview scaler.
//
// The scaler walks an output grid in raster order. Each slave beat carries
// the channel bytes of the source pixel fetched at the element index given
// by the previous master beat (index 0 after reset or after any register
// write). Each master beat carries the packed ARGB pixel, the destination
// row and column and the element index to fetch next; tlast marks the final
// pixel of the frame, after which the walk wraps to the first pixel.
// Registers are written on the cfg channel (always ready); the user must
// write them only while no beat is in flight, which the block does not
// enforce. A write restarts the walk and the step divider (one load, 13
// restoring steps, one multiply); the slave side waits until it finishes.
// After reset the step values match the reset geometry, so the slave side
// is ready at once. Beats pass the walk and output registers, one per cycle
// while tready is high. The two pipeline registers decouple the sides, so
// the slave side keeps taking beats while one result waits; when the
// receiver stalls, results hold and tready drops once both are full.
module nearest_neighbor_preview_scaler #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [12:0] cfg_data_i,
  // Source samples in.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: sample0 [7:0], sample1 [15:8], sample2 [23:16], sample3 [31:24].
  input  logic [31:0] s_axis_tdata,
  // Scaled pixels out.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: pixel_word [31:0], dest_row [43:32], dest_col [55:44],
  // next_source_index [81:56], zero fill [87:82].
  output logic [87:0] m_axis_tdata,
  // tlast: frame_last.
  output logic        m_axis_tlast
);
  import nnps_pkg::*;

  localparam int unsigned MaxDimC = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam logic [DIM_W-1:0] MaxDim = DIM_W'(MaxDimC);

  logic [DIM_W-1:0] src_w_q, src_h_q, out_w_q, out_h_q;
  logic [1:0]       mode_q;
  logic             mirror_q;
  logic             cfg_hit;
  nnps_geom_t       geom;
  nnps_step_t       step;
  logic             div_busy, walk_ready, in_accept;
  logic             s1_valid, s2_ready;
  nnps_stage_t      s1_stage;
  logic [31:0]      pixel_word;
  logic [11:0]      dest_row, dest_col;
  logic [25:0]      next_index;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > MaxDim) begin
      r = MaxDim;
    end
    return r;
  endfunction

  // Register decode: only indexes in the list count as writes.
  always_comb begin
    case (cfg_index_i)
      CFG_SRC_WIDTH, CFG_SRC_HEIGHT, CFG_OUT_WIDTH, CFG_OUT_HEIGHT,
      CFG_CHANNEL_MODE, CFG_MIRROR_ROWS: cfg_hit = cfg_valid_i;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q  <= DIM_W'(1);
      src_h_q  <= DIM_W'(1);
      out_w_q  <= DIM_W'(1);
      out_h_q  <= DIM_W'(1);
      mode_q   <= MODE_RGB;
      mirror_q <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SRC_WIDTH:    src_w_q  <= cfg_data_i;
        CFG_SRC_HEIGHT:   src_h_q  <= cfg_data_i;
        CFG_OUT_WIDTH:    out_w_q  <= cfg_data_i;
        CFG_OUT_HEIGHT:   out_h_q  <= cfg_data_i;
        CFG_CHANNEL_MODE: mode_q   <= cfg_data_i[1:0];
        CFG_MIRROR_ROWS:  mirror_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Effective dimensions.
  always_comb begin
    geom.src_w = clamp_dim(src_w_q);
    geom.src_h = clamp_dim(src_h_q);
    geom.out_w = clamp_dim(out_w_q);
    geom.out_h = clamp_dim(out_h_q);
  end

  nnps_step_div u_step_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cfg_hit),
    .geom_i  (geom),
    .step_o  (step),
    .busy_o  (div_busy)
  );

  assign s_axis_tready = walk_ready && !div_busy;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  nnps_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_hit),
    .accept_i     (in_accept),
    .samples_i    (s_axis_tdata),
    .geom_i       (geom),
    .step_i       (step),
    .mirror_i     (mirror_q),
    .down_ready_i (s2_ready),
    .ready_o      (walk_ready),
    .valid_o      (s1_valid),
    .stage_o      (s1_stage)
  );

  nnps_pack u_pack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s1_valid),
    .stage_i      (s1_stage),
    .mode_i       (mode_q),
    .ready_o      (s2_ready),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .pixel_word_o (pixel_word),
    .dest_row_o   (dest_row),
    .dest_col_o   (dest_col),
    .next_index_o (next_index),
    .last_o       (m_axis_tlast)
  );

  assign m_axis_tdata = {6'b0, next_index, dest_col, dest_row, pixel_word};

endmodule
